### rtl/chunked_heap_range_splitter_core_macros.svh
// Assertion macros for the chunked heap range splitter.
// Expects i_clk and i_rst_n in the scope of the module that uses them.
`ifndef CHUNKED_HEAP_RANGE_SPLITTER_CORE_MACROS_SVH
`define CHUNKED_HEAP_RANGE_SPLITTER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define CHRS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define CHRS_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/chrs_pkg.sv
// Shared widths, register codes and reset values of the chunked heap range splitter.
// No dependencies.
`default_nettype none

package chrs_pkg;

    localparam int OFS_W       = 32;  // input offset
    localparam int LEN_W       = 32;  // input length
    localparam int END_W       = OFS_W + 1;  // offset + length
    localparam int SH_W        = 5;   // shift registers
    localparam int HC_W        = 13;  // heap size in base chunks
    localparam int MAX_CHUNKS  = 4096;
    localparam int ADR_W       = HC_W + (1 << SH_W) - 1;  // heap byte address
    localparam int IDX_W       = 12;
    localparam int COFF_W      = 31;
    localparam int SOFF_W      = 31;
    localparam int CLEN_W      = 32;
    localparam int CFG_W       = HC_W;
    localparam int CFG_IDX_W   = 2;
    localparam int SPREAD_MAX  = 30;  // largest base_shift - start_shift

    localparam int IN_DATA_W   = OFS_W + LEN_W;
    localparam int OUT_FLD_W   = IDX_W + COFF_W + SOFF_W + CLEN_W;
    localparam int OUT_DATA_W  = ((OUT_FLD_W + 7) / 8) * 8;

    localparam logic [SH_W-1:0] START_SHIFT_RST = 5'd12;
    localparam logic [SH_W-1:0] BASE_SHIFT_RST  = 5'd21;
    localparam logic [HC_W-1:0] HEAP_CHUNKS_RST = 13'd2048;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_SHIFT = 2'd0,
        CFG_BASE_SHIFT  = 2'd1,
        CFG_HEAP_CHUNKS = 2'd2
    } t_cfg_idx;

endpackage

`default_nettype wire

### rtl/chunked_heap_range_splitter_core.sv
// Chunked heap range splitter: cuts a byte range into per-chunk copy segments.
// Depends on chrs_pkg and chunked_heap_range_splitter_core_macros.svh.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata: offset, length
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata: index, chunk/source offset,
//                                                 copy length; tlast; tuser: status
//  cfg       in   i_cfg_we (no wait)              i_cfg_idx, i_cfg_data
//
// A range passes ST_PREP, ST_CHECK and ST_INIT; each chunk walked then takes ST_ADV
// (add for the chunk end) and ST_SEG (compare/subtract step), each segment ST_OUT.
// Walking starts at the first chunk of the region that holds the offset, so up
// to n - 1 chunks below the offset may be skipped (n = base_shift - start_shift + 1).
// Reset is synchronous; it restores the configuration registers and idles the walker.
// The walker holds in the output state until the result word is taken; no new
// range is accepted until the last word of the current one has gone.
`default_nettype none
`include "chunked_heap_range_splitter_core_macros.svh"

module chunked_heap_range_splitter_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // offset [31:0], length [63:32]
    input  wire logic [chrs_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // chunk_index [11:0], chunk_offset [42:12], source_offset [73:43],
    // copy_length [105:74], zero fill above
    output logic [chrs_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata,
    output logic                                  o_m_axis_tlast,
    // status [0]
    output logic                                  o_m_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    input  wire logic                             i_cfg_we,
    input  wire logic [chrs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [chrs_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int ADR_W = chrs_pkg::ADR_W;
    localparam int END_W = chrs_pkg::END_W;
    localparam int SH_W  = chrs_pkg::SH_W;
    localparam int HC_W  = chrs_pkg::HC_W;
    localparam int IDX_W = chrs_pkg::IDX_W;

    typedef enum logic [2:0] {
        ST_IDLE, ST_PREP, ST_CHECK, ST_INIT, ST_ADV, ST_SEG, ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RGN_BOT, RGN_BASE, RGN_TOP
    } t_region;

    // Configuration registers.
    logic [SH_W-1:0] r_cfg_start;
    logic [SH_W-1:0] r_cfg_base;
    logic [HC_W-1:0] r_cfg_heap;

    // Walker state.
    t_state                    r_state;
    logic [chrs_pkg::OFS_W-1:0] r_ofs;
    logic [chrs_pkg::LEN_W-1:0] r_len;
    logic [SH_W-1:0]           r_s;
    logic [SH_W-1:0]           r_b;
    logic [SH_W-1:0]           r_n;
    logic [HC_W-1:0]           r_hcc;
    logic [ADR_W-1:0]          r_h;
    logic [ADR_W-1:0]          r_top_base;
    logic [END_W-1:0]          r_end;
    logic [END_W-1:0]          r_jhi;
    logic [chrs_pkg::OFS_W-1:0] r_jcur;
    logic                      r_err;
    t_region                   r_region;
    logic [IDX_W-1:0]          r_idx;
    logic [ADR_W-1:0]          r_start;
    logic [ADR_W-1:0]          r_cend;
    logic [SH_W-1:0]           r_exp;
    logic [END_W-1:0]          r_cur;
    logic                      r_done;

    // Result word.
    logic [IDX_W-1:0]            r_o_idx;
    logic [chrs_pkg::COFF_W-1:0] r_o_coff;
    logic [chrs_pkg::SOFF_W-1:0] r_o_soff;
    logic [chrs_pkg::CLEN_W-1:0] r_o_len;
    logic                        r_o_last;
    logic                        r_o_status;

    // Effective geometry from the registers.
    logic [SH_W-1:0] s_clip;
    logic [SH_W-1:0] s_eff;
    logic [SH_W-1:0] n_geom;
    logic [HC_W-1:0] hcc;

    always_comb begin
        s_clip = (r_cfg_start > r_cfg_base) ? r_cfg_base : r_cfg_start;
        if ((r_cfg_base - s_clip) > SH_W'(chrs_pkg::SPREAD_MAX)) begin
            s_eff = r_cfg_base - SH_W'(chrs_pkg::SPREAD_MAX);
        end else begin
            s_eff = s_clip;
        end
        n_geom = r_cfg_base - s_eff + SH_W'(1);
        if (r_cfg_heap < HC_W'(2)) begin
            hcc = HC_W'(2);
        end else if (r_cfg_heap > HC_W'(chrs_pkg::MAX_CHUNKS)) begin
            hcc = HC_W'(chrs_pkg::MAX_CHUNKS);
        end else begin
            hcc = r_cfg_heap;
        end
    end

    // Per-range helpers.
    logic [ADR_W-1:0] base_sz;
    logic [ADR_W-1:0] ofs_x;
    logic [ADR_W-1:0] end_x;
    logic [ADR_W-1:0] cur_x;
    logic [SH_W-1:0]  exp_top_first;
    logic [IDX_W-1:0] idx_top_first;
    logic [HC_W-1:0]  two_n;
    logic [HC_W-1:0]  jmax;
    logic             touch_base;
    logic             bad_idx;
    logic [HC_W-1:0]  base_idx;
    logic [ADR_W-1:0] seg_end;

    always_comb begin
        base_sz       = ADR_W'(1) << r_b;
        ofs_x         = ADR_W'(r_ofs);
        end_x         = ADR_W'(r_end);
        cur_x         = ADR_W'(r_cur);
        exp_top_first = (r_n == SH_W'(1)) ? r_b : (r_b - SH_W'(1));
        two_n         = {{(HC_W-SH_W-1){1'b0}}, r_n, 1'b0};
        idx_top_first = IDX_W'(two_n - HC_W'(1));
        // Highest base chunk the range touches decides an index overflow.
        if (r_jhi < END_W'(r_hcc - HC_W'(2))) begin
            jmax = r_jhi[HC_W-1:0];
        end else begin
            jmax = r_hcc - HC_W'(2);
        end
        touch_base = (r_hcc > HC_W'(2)) && (ofs_x < r_top_base) && (end_x > base_sz);
        bad_idx    = touch_base && ((two_n + jmax) > HC_W'(chrs_pkg::MAX_CHUNKS));
        base_idx   = two_n + r_jcur[HC_W-1:0] - HC_W'(1);
        seg_end    = (r_cend < end_x) ? r_cend : end_x;
    end

    // Step to the chunk that starts where the current one ends.
    t_region          n_region;
    logic [IDX_W-1:0] n_idx;
    logic [SH_W-1:0]  n_exp;

    always_comb begin
        n_region = r_region;
        n_idx    = r_idx + IDX_W'(1);
        n_exp    = r_exp;
        unique case (r_region)
            RGN_BOT: begin
                if (r_idx == (IDX_W'(r_n) - IDX_W'(1))) begin
                    if (r_hcc == HC_W'(2)) begin
                        n_region = RGN_TOP;
                        n_idx    = idx_top_first;
                        n_exp    = exp_top_first;
                    end else begin
                        n_region = RGN_BASE;
                        n_idx    = IDX_W'(two_n);
                        n_exp    = r_b;
                    end
                end else if (r_idx != '0) begin
                    n_exp = r_exp + SH_W'(1);
                end
            end
            RGN_BASE: begin
                if (r_cend == r_top_base) begin
                    n_region = RGN_TOP;
                    n_idx    = idx_top_first;
                    n_exp    = exp_top_first;
                end
            end
            RGN_TOP: begin
                // Top chunks count down toward the heap end, halving in size.
                n_idx = r_idx - IDX_W'(1);
                if (r_idx != (IDX_W'(r_n) + IDX_W'(1))) begin
                    n_exp = r_exp - SH_W'(1);
                end
            end
            default: begin
                n_region = RGN_BOT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_start <= chrs_pkg::START_SHIFT_RST;
            r_cfg_base  <= chrs_pkg::BASE_SHIFT_RST;
            r_cfg_heap  <= chrs_pkg::HEAP_CHUNKS_RST;
            r_state     <= ST_IDLE;
            r_done      <= 1'b0;
            r_region    <= RGN_BOT;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    chrs_pkg::CFG_START_SHIFT: r_cfg_start <= i_cfg_data[SH_W-1:0];
                    chrs_pkg::CFG_BASE_SHIFT:  r_cfg_base  <= i_cfg_data[SH_W-1:0];
                    chrs_pkg::CFG_HEAP_CHUNKS: r_cfg_heap  <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_ofs   <= i_s_axis_tdata[chrs_pkg::OFS_W-1:0];
                        r_len   <= i_s_axis_tdata[chrs_pkg::IN_DATA_W-1:chrs_pkg::OFS_W];
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    // Latch the geometry and the range end.
                    r_s     <= s_eff;
                    r_b     <= r_cfg_base;
                    r_n     <= n_geom;
                    r_hcc   <= hcc;
                    r_h     <= ADR_W'(hcc) << r_cfg_base;
                    r_end   <= END_W'(r_ofs) + END_W'(r_len);
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    r_top_base <= r_h - base_sz;
                    r_err      <= (r_len == '0) || (ADR_W'(r_len) > base_sz) || (end_x > r_h);
                    r_jhi      <= (r_end - END_W'(1)) >> r_b;
                    r_jcur     <= r_ofs >> r_b;
                    r_cur      <= END_W'(r_ofs);
                    r_state    <= ST_INIT;
                end
                ST_INIT: begin
                    if (r_err || bad_idx) begin
                        // Single error word, all fields zero.
                        r_o_idx    <= '0;
                        r_o_coff   <= '0;
                        r_o_soff   <= '0;
                        r_o_len    <= '0;
                        r_o_last   <= 1'b1;
                        r_o_status <= 1'b1;
                        r_done     <= 1'b1;
                        r_state    <= ST_OUT;
                    end else begin
                        // Seat the walker on the first chunk of the offset's region.
                        if (ofs_x < base_sz) begin
                            r_region <= RGN_BOT;
                            r_idx    <= '0;
                            r_start  <= '0;
                            r_exp    <= r_s;
                        end else if (ofs_x >= r_top_base) begin
                            r_region <= RGN_TOP;
                            r_idx    <= idx_top_first;
                            r_start  <= r_top_base;
                            r_exp    <= exp_top_first;
                        end else begin
                            r_region <= RGN_BASE;
                            r_idx    <= IDX_W'(base_idx);
                            r_start  <= ADR_W'(r_jcur) << r_b;
                            r_exp    <= r_b;
                        end
                        r_done  <= 1'b0;
                        r_state <= ST_ADV;
                    end
                end
                ST_ADV: begin
                    r_cend  <= r_start + (ADR_W'(1) << r_exp);
                    r_state <= ST_SEG;
                end
                ST_SEG: begin
                    if (r_cend <= cur_x) begin
                        // Chunk lies below the range: drop it and advance.
                        r_region <= n_region;
                        r_idx    <= n_idx;
                        r_exp    <= n_exp;
                        r_start  <= r_cend;
                        r_state  <= ST_ADV;
                    end else begin
                        r_o_idx    <= r_idx;
                        r_o_coff   <= chrs_pkg::COFF_W'(cur_x - r_start);
                        r_o_soff   <= chrs_pkg::SOFF_W'(r_cur - END_W'(r_ofs));
                        r_o_len    <= chrs_pkg::CLEN_W'(seg_end - cur_x);
                        r_o_last   <= (seg_end == end_x);
                        r_o_status <= 1'b0;
                        r_done     <= (seg_end == end_x);
                        r_cur      <= END_W'(seg_end);
                        r_state    <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // Hold the word until it is taken.
                    if (i_m_axis_tready) begin
                        if (r_done) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_region <= n_region;
                            r_idx    <= n_idx;
                            r_exp    <= n_exp;
                            r_start  <= r_cend;
                            r_state  <= ST_ADV;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = (r_state == ST_OUT);
    assign o_m_axis_tlast  = r_o_last;
    assign o_m_axis_tuser  = r_o_status;
    assign o_m_axis_tdata  = chrs_pkg::OUT_DATA_W'({r_o_len, r_o_soff, r_o_coff, r_o_idx});

    // Checks on the walker.
    `CHRS_ASSERT_IMP(a_err_is_last, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast, "error word without last")
    `CHRS_ASSERT_IMP(a_err_zero, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tdata == '0, "error word carries data")
    `CHRS_ASSERT_IMP(a_no_overlap, o_m_axis_tvalid, !o_s_axis_tready, "input ready while a word is pending")
    `CHRS_ASSERT_NXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready && !o_m_axis_tvalid, "walker not busy after accept")

endmodule

`default_nettype wire

### verif/chunked_heap_range_splitter_core_tb.sv
// Self-checking testbench for chunked_heap_range_splitter_core: ranges in, chunk segments out.
// Needs chrs_pkg and the RTL of the block; a scoreboard class predicts each segment word.

module chunked_heap_range_splitter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import chrs_pkg::*;

    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int PHASE_ITEMS   = 50;    // random ranges per register setting
    localparam int PHASES        = 9;
    localparam int SETTLE_CYCLES = 4;     // let the walker go idle before a register write
    localparam int TAIL_CYCLES   = 120;   // setup + full walk of the largest range
    localparam longint unsigned SPAN_32 = 64'h1_0000_0000;

    // One segment word as it leaves the block.
    typedef struct packed {
        logic [IDX_W-1:0]  idx;
        logic [COFF_W-1:0] coff;
        logic [SOFF_W-1:0] soff;
        logic [CLEN_W-1:0] clen;
        logic              last;
        logic              status;
    } seg_t;

    // Holds the register copy, predicts the segment words of each accepted range
    // and checks the words that come out against them in order.
    class segment_board;
        logic [SH_W-1:0] start_reg;
        logic [SH_W-1:0] base_reg;
        logic [HC_W-1:0] heap_reg;
        seg_t            queued_segs[$];
        int              bad_words;

        function new();
            start_reg = START_SHIFT_RST;
            base_reg  = BASE_SHIFT_RST;
            heap_reg  = HEAP_CHUNKS_RST;
            bad_words = 0;
        endfunction

        function void write_reg(t_cfg_idx sel, logic [CFG_W-1:0] data);
            case (sel)
                CFG_START_SHIFT: start_reg = data[SH_W-1:0];
                CFG_BASE_SHIFT:  base_reg  = data[SH_W-1:0];
                CFG_HEAP_CHUNKS: heap_reg  = data[HC_W-1:0];
                default: ;
            endcase
        endfunction

        // Effective shifts, region count and heap size after the clamps.
        function void geometry(output longint unsigned s, output longint unsigned b,
                               output longint unsigned n, output longint unsigned h);
            longint unsigned hc;
            s  = start_reg;
            b  = base_reg;
            hc = heap_reg;
            if (s > b) s = b;
            if (b - s > SPREAD_MAX) s = b - SPREAD_MAX;
            n = b - s + 1;
            if (hc < 2) hc = 2;
            if (hc > MAX_CHUNKS) hc = MAX_CHUNKS;
            h = hc << b;
        endfunction

        function longint unsigned width_of(longint unsigned v);
            longint unsigned k;
            k = 0;
            while (v != 0) begin
                v = v >> 1;
                k++;
            end
            return k;
        endfunction

        function void report(string what, seg_t want, seg_t got);
            bad_words++;
            if (bad_words <= 10)
                $display("%s: exp idx=%0d coff=%h soff=%h len=%h last=%b st=%b | got idx=%0d coff=%h soff=%h len=%h last=%b st=%b",
                         what, want.idx, want.coff, want.soff, want.clen, want.last,
                         want.status, got.idx, got.coff, got.soff, got.clen, got.last,
                         got.status);
        endfunction

        // Walk the range chunk by chunk and queue the words it must produce.
        function void note_range(logic [OFS_W-1:0] ofs, logic [LEN_W-1:0] len);
            longint unsigned s, b, n, h, o, l, fin, cur;
            longint unsigned base_sz, small_sz, idx, cstart, csize, cend, r, k;
            seg_t            segs[$];
            seg_t            sg;
            bit              bad;
            geometry(s, b, n, h);
            o        = ofs;
            l        = len;
            fin      = o + l;
            base_sz  = 64'd1 << b;
            small_sz = 64'd1 << s;
            bad      = 1'b0;
            sg        = '0;
            sg.last   = 1'b1;
            sg.status = 1'b1;
            if (l == 0 || l > base_sz || fin > h) begin
                queued_segs.push_back(sg);
                return;
            end
            cur = o;
            while (cur < fin && segs.size() < 32) begin
                if (cur < base_sz) begin
                    if (cur < small_sz) begin
                        idx = 0; cstart = 0; csize = small_sz;
                    end else begin
                        k = width_of(cur);
                        idx = k - s; cstart = 64'd1 << (k - 1); csize = cstart;
                    end
                end else if (cur >= h - base_sz) begin
                    r = h - 1 - cur;
                    if (r < small_sz) begin
                        idx = n; cstart = h - small_sz; csize = small_sz;
                    end else begin
                        k = width_of(r);
                        idx = n + k - s; cstart = h - (64'd1 << k); csize = 64'd1 << (k - 1);
                    end
                end else begin
                    idx = 2 * n + (cur >> b) - 1; cstart = (cur >> b) << b; csize = base_sz;
                end
                cend = cstart + csize;
                if (cend > fin) cend = fin;
                if (idx >= MAX_CHUNKS) bad = 1'b1;
                sg.idx    = IDX_W'(idx);
                sg.coff   = COFF_W'(cur - cstart);
                sg.soff   = SOFF_W'(cur - o);
                sg.clen   = CLEN_W'(cend - cur);
                sg.last   = 1'b0;
                sg.status = 1'b0;
                segs.push_back(sg);
                cur = cend;
            end
            if (bad || cur < fin) begin
                sg = '0;
                sg.last   = 1'b1;
                sg.status = 1'b1;
                queued_segs.push_back(sg);
                return;
            end
            foreach (segs[i]) begin
                sg = segs[i];
                sg.last = (i == segs.size() - 1);
                queued_segs.push_back(sg);
            end
        endfunction

        function void check_segment(seg_t got);
            seg_t want;
            if (queued_segs.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            want = queued_segs.pop_front();
            if (got.idx !== want.idx || got.coff !== want.coff || got.soff !== want.soff ||
                got.clen !== want.clen || got.last !== want.last ||
                got.status !== want.status)
                report("word mismatch", want, got);
        endfunction
    endclass

    // Block inputs start at known values; everything is driven at the rising edge.
    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata   = '0;
    logic                  i_s_axis_tvalid  = 1'b0;
    logic                  i_m_axis_tready  = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = CFG_START_SHIFT;
    logic [CFG_W-1:0]      i_cfg_data       = '0;
    logic                  o_s_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tlast;
    logic                  o_m_axis_tuser;
    logic                  o_m_axis_tvalid;

    bit           steady   = 1'b0;  // both sides run with no idle cycles
    bit           hold_req = 1'b0;  // ask the receiver for one long hold-off
    segment_board board;

    always #1 i_clk = ~i_clk;

    chunked_heap_range_splitter_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // Offer one range after a random gap; hold it until the block takes the word.
    task automatic send_range(input logic [OFS_W-1:0] ofs, input logic [LEN_W-1:0] len);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {len, ofs};
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_range(ofs, len);
    endtask

    // Take segment words with random stalls; honor a hold-off request when raised.
    task automatic take_segments();
        int unsigned stall;
        seg_t        got;
        forever begin
            if (hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = steady ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            got.idx    = o_m_axis_tdata[0 +: IDX_W];
            got.coff   = o_m_axis_tdata[IDX_W +: COFF_W];
            got.soff   = o_m_axis_tdata[IDX_W + COFF_W +: SOFF_W];
            got.clen   = o_m_axis_tdata[IDX_W + COFF_W + SOFF_W +: CLEN_W];
            got.last   = o_m_axis_tlast;
            got.status = o_m_axis_tuser;
            board.check_segment(got);
        end
    endtask

    // Drop valid and wait until every predicted word has been taken.
    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (board.queued_segs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all three registers on back-to-back cycles; the block must be idle.
    task automatic set_config(input logic [CFG_W-1:0] start_v, input logic [CFG_W-1:0] base_v,
                              input logic [CFG_W-1:0] heap_v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_START_SHIFT;
        i_cfg_data <= start_v;
        @(posedge i_clk);
        board.write_reg(CFG_START_SHIFT, start_v);
        i_cfg_idx  <= CFG_BASE_SHIFT;
        i_cfg_data <= base_v;
        @(posedge i_clk);
        board.write_reg(CFG_BASE_SHIFT, base_v);
        i_cfg_idx  <= CFG_HEAP_CHUNKS;
        i_cfg_data <= heap_v;
        @(posedge i_clk);
        board.write_reg(CFG_HEAP_CHUNKS, heap_v);
        i_cfg_we <= 1'b0;
    endtask

    // Shift value with junk in the unused upper bits of the write data.
    function automatic logic [CFG_W-1:0] shift_word(int unsigned sh);
        return {(CFG_W - SH_W)'($urandom), SH_W'(sh)};
    endfunction

    // Mostly in-heap ranges near chunk edges, some bad ones, some raw noise.
    task automatic send_random_range();
        longint unsigned s, b, n, h, base_sz, offmax, pos, room, ofs, len;
        longint          nudged;
        int unsigned     pick;
        board.geometry(s, b, n, h);
        base_sz = 64'd1 << b;
        offmax  = (h < SPAN_32 ? h : SPAN_32) - 1;
        pick    = $urandom_range(0, 99);
        if (pick < 10) begin
            ofs = $urandom;
            len = $urandom;
        end else if (pick < 22) begin
            ofs = $urandom_range(0, offmax);
            case ($urandom_range(0, 2))
                0: len = 0;
                1: len = base_sz + $urandom_range(1, 16);
                default: begin
                    // run past the heap end where the end is reachable
                    if (h <= SPAN_32) begin
                        ofs = h - 1 - $urandom_range(0, (base_sz < 256 ? base_sz : 256) - 1);
                        len = (h - ofs) + $urandom_range(1, 16);
                    end else begin
                        ofs = offmax;
                        len = base_sz;
                    end
                end
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0: pos = $urandom_range(0, offmax);
                1: pos = 64'd1 << $urandom_range(0, b);
                2: pos = h - (64'd1 << $urandom_range(0, b));
                3: pos = longint'($urandom_range(1, (h >> b) - 1)) << b;
                default: pos = h - (longint'($urandom_range(1, 8)) << b);
            endcase
            // land on, just below or just above the edge
            nudged = longint'(pos) + longint'($urandom_range(0, 6)) - 3;
            if (nudged < 0) nudged = 0;
            if (nudged > longint'(offmax)) nudged = offmax;
            ofs  = nudged;
            room = h - ofs;
            if (room > base_sz) room = base_sz;
            case ($urandom_range(0, 9))
                0, 1:    len = room;
                2, 3, 4: len = $urandom_range(1, room);
                default: len = $urandom_range(1, room < 256 ? room : 256);
            endcase
        end
        send_range(OFS_W'(ofs), LEN_W'(len));
    endtask

    initial begin
        #2_000_000;
        $display("FAIL chunked_heap_range_splitter_core");
        $finish;
    end

    initial begin
        int unsigned s_pick, b_pick, hc_pick;
        board = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        fork
            take_segments();
        join_none

        // Directed ranges at the reset setting: heap of 2^32 bytes, 4 KiB to 2 MiB chunks.
        send_range(32'h0000_0000, 32'h0000_0001);
        send_range(32'h0000_0000, 32'h0020_0000);  // every bottom chunk
        send_range(32'hFFFF_FFFF, 32'h0000_0001);  // top byte
        send_range(32'hFFE0_0000, 32'h0020_0000);  // every top chunk
        send_range(32'h001F_FFFF, 32'h0000_0002);  // bottom into first whole chunk
        send_range(32'h003F_FFF0, 32'h0000_0020);  // across two whole chunks
        send_range(32'h0000_0000, 32'h0000_0000);  // zero length
        send_range(32'h0000_0000, 32'h0020_0001);  // longer than a base chunk
        send_range(32'hFFFF_FFFF, 32'h0000_0002);  // past the heap end
        send_range(32'h0000_0800, 32'h0000_1000);  // smallest chunk into the next
        send_range(32'hFFFF_FFFF, 32'h8000_0000);
        send_range(32'h0000_0000, 32'hFFFF_FFFF);
        send_range(32'h000F_FFFF, 32'h0000_0008);  // lower chunks are skipped
        send_range(32'h7FFF_FFF0, 32'h0020_0000);
        send_range(32'hFFDF_FFFF, 32'h0000_0002);  // whole chunk into the top set
        drain();

        // Spread above the limit: start shift 0 with base shift 31, 31 segments per half.
        set_config(shift_word(0), shift_word(31), 13'd2);
        send_range(32'h0000_0000, 32'h8000_0000);
        send_range(32'h8000_0000, 32'h8000_0000);
        send_range(32'h7FFF_FFFF, 32'h0000_0002);
        drain();

        // Chunk index runs out near the top of a full heap of 256-byte chunks.
        set_config(shift_word(6), shift_word(8), 13'd4096);
        send_range(32'h000F_FA00, 32'h0000_0001);
        send_range(32'h000F_F900, 32'h0000_0100);
        send_range(32'h000F_FFFF, 32'h0000_0001);
        drain();

        // Start shift above base shift and heap size below the minimum.
        set_config(shift_word(25), shift_word(10), 13'd0);
        send_range(32'h0000_03FF, 32'h0000_0002);
        send_range(32'h0000_0400, 32'h0000_0400);
        send_range(32'h0000_0000, 32'h0000_0800);
        drain();

        // Random ranges under a series of settings, extremes first.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin s_pick = 12; b_pick = 21; hc_pick = 2048; end
                1: begin s_pick = 6;  b_pick = 6;  hc_pick = 2;    end
                2: begin s_pick = 30; b_pick = 31; hc_pick = 4096; end
                3: begin s_pick = 6;  b_pick = 31; hc_pick = 2;    end
                4: begin s_pick = 6;  b_pick = 8;  hc_pick = 4096; end
                5: begin s_pick = 0;  b_pick = 31; hc_pick = 2;    end
                6: begin s_pick = 25; b_pick = 10; hc_pick = 8191; end
                7: begin
                    s_pick  = $urandom_range(6, 30);
                    b_pick  = $urandom_range(s_pick, 31);
                    hc_pick = $urandom_range(2, 4096);
                end
                default: begin
                    s_pick  = $urandom_range(0, 31);
                    b_pick  = $urandom_range(0, 31);
                    hc_pick = $urandom_range(0, 8191);
                end
            endcase
            set_config(shift_word(s_pick), shift_word(b_pick), CFG_W'(hc_pick));
            steady = (p % 3 == 2);
            // stall the output long enough that the input backs up behind it
            if (p == 0 || p == 4) hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++) send_random_range();
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (board.bad_words == 0 && board.queued_segs.size() == 0) begin
            $display("PASS chunked_heap_range_splitter_core");
        end else begin
            $display("FAIL chunked_heap_range_splitter_core");
        end
        $finish;
    end

endmodule
